FILE: design/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every edge outside reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed");
// implication whose consequent is checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed");
`endif

FILE: design/rcdt_pkg.sv
// Package: types, constants and codes of the refcounted dedup table
package rcdt_pkg;
	localparam int ENTRIES    = 256;
	localparam int IDX_BITS   = 8;
	localparam int CNT_BITS   = 16;
	localparam logic [63:0] FNV_OFFSET = 64'd14695981039346656037;
	localparam logic [63:0] FNV_PRIME  = 64'd1099511628211;

	localparam logic CMD_INTERN  = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	localparam logic [2:0] ST_REUSED  = 3'd0;
	localparam logic [2:0] ST_ALLOC   = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_DROPPED = 3'd3;
	localparam logic [2:0] ST_FREED   = 3'd4;
	localparam logic [2:0] ST_IGNORED = 3'd5;

	typedef struct packed {
		logic        command;
		logic [63:0] key_value;
		logic [7:0]  release_index;
	} request_t;

	typedef struct packed {
		logic [7:0]  slot_index;
		logic [2:0]  status;
		logic [63:0] key_hash;
		logic [15:0] ref_count;
	} result_t;
endpackage

FILE: design/rcdt_hash.sv
// Iterative FNV-1a 64 hash: one byte per round, product split in 32-bit parts
module rcdt_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [63:0] key,
	output logic        done,
	output logic [63:0] hash
);
	import rcdt_pkg::*;

	typedef enum logic [3:0] {
		H_IDLE = 4'b0001,
		H_XOR  = 4'b0010,
		H_MUL  = 4'b0100,
		H_ADD  = 4'b1000
	} hstate_t;

	hstate_t     state_q;
	logic [2:0]  byte_q;
	logic [63:0] key_q, h_q, lo_q, hi_q;
	logic [63:0] x;

	// prime = 0x100_0000_01B3: h*p = h*0x1B3 + (h << 40)
	always_comb x = h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			byte_q  <= '0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				H_IDLE: begin
					if (go) begin
						key_q   <= key;
						h_q     <= FNV_OFFSET;
						byte_q  <= '0;
						state_q <= H_XOR;
					end
				end
				H_XOR: begin
					h_q     <= h_q ^ {56'd0, key_q[7:0]};
					key_q   <= key_q >> 8;
					state_q <= H_MUL;
				end
				H_MUL: begin
					lo_q    <= {32'd0, x[31:0]} * 64'h1B3;
					hi_q    <= {32'd0, x[63:32]} * 64'h1B3;
					state_q <= H_ADD;
				end
				H_ADD: begin
					h_q    <= lo_q + {hi_q[31:0], 32'd0} + {x[23:0], 40'd0};
					byte_q <= byte_q + 3'd1;
					if (byte_q == 3'd7) begin
						done    <= 1'b1;
						state_q <= H_IDLE;
					end else begin
						state_q <= H_XOR;
					end
				end
				default: state_q <= H_IDLE;
			endcase
		end
	end

	always_comb hash = h_q;
endmodule

FILE: design/refcounted_dedup_table.sv
// Top level: refcounted dedup table with sequencer, entry memories and free stack
// Intern hashes the key, then reads and compares each used slot in turn (S_RD, S_CMP)
// and stops at a match; else it pops a freed slot or takes the next unused one and
// stores the key there, or reports full. Release updates an occupied slot's count.
// Throughput: one request at a time; busy falls with done, so the next request can be
// accepted at the edge that ends the result cycle. The receiver cannot stall.
// Reset clears the free depth, used count, scan index and occupied bits; memory contents stay until written.
module refcounted_dedup_table (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  rcdt_pkg::request_t request,
	output logic               done,
	output rcdt_pkg::result_t  result
);
	import rcdt_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_HASH  = 9'b000000010,
		S_RD    = 9'b000000100,
		S_CMP   = 9'b000001000,
		S_POP   = 9'b000010000,
		S_STORE = 9'b000100000,
		S_RRD   = 9'b001000000,
		S_RUPD  = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	state_t      state_q;
	logic [63:0] key_q, hash_q;
	logic [7:0]  ridx_q;
	logic [8:0]  scan_q, free_depth_q, used_q;
	logic [7:0]  slot_q;
	logic [ENTRIES-1:0] occ_q;

	logic [63:0] key_mem [ENTRIES];
	logic [63:0] hash_mem [ENTRIES];
	logic [15:0] refs_mem [ENTRIES];
	logic [7:0]  stack_mem [ENTRIES];
	logic [63:0] key_rd_q;
	logic [15:0] refs_rd_q;
	logic [7:0]  stack_rd_q;
	logic [7:0]  rd_addr;
	logic        ref_we;
	logic [7:0]  ref_wa;
	logic [15:0] ref_wd;
	logic        hash_go, hash_done;
	logic [63:0] hash_val;

	rcdt_hash u_hash (
		.clk(clk), .arst_n(arst_n), .go(hash_go), .key(request.key_value),
		.done(hash_done), .hash(hash_val)
	);

	assign hash_go = (state_q == S_IDLE) && start && (request.command == CMD_INTERN);
	assign busy    = (state_q != S_IDLE);
	assign rd_addr = (state_q == S_IDLE) ? request.release_index
		: (state_q == S_RRD || state_q == S_RUPD) ? ridx_q : scan_q[7:0];

	always_ff @(posedge clk) begin
		key_rd_q   <= key_mem[rd_addr];
		refs_rd_q  <= refs_mem[rd_addr];
		stack_rd_q <= stack_mem[free_depth_q[7:0] - 8'd1];
		if (ref_we) refs_mem[ref_wa] <= ref_wd;
		if (state_q == S_STORE) begin
			key_mem[slot_q]  <= key_q;
			hash_mem[slot_q] <= hash_q;
		end
		if (state_q == S_RUPD && refs_rd_q == 16'd1)
			stack_mem[free_depth_q[7:0]] <= ridx_q;
	end

	always_comb begin
		ref_we = 1'b0;
		ref_wa = slot_q;
		ref_wd = 16'd1;
		if (state_q == S_STORE) ref_we = 1'b1;
		if (state_q == S_CMP && occ_q[scan_q[7:0]] && key_rd_q == key_q) begin
			ref_we = 1'b1;
			ref_wa = scan_q[7:0];
			ref_wd = (refs_rd_q == 16'hFFFF) ? refs_rd_q : refs_rd_q + 16'd1;
		end
		if (state_q == S_RUPD) begin
			ref_we = 1'b1;
			ref_wd = refs_rd_q - 16'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			occ_q        <= '0;
			free_depth_q <= '0;
			used_q       <= '0;
			scan_q       <= '0;
			done         <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						key_q  <= request.key_value;
						ridx_q <= request.release_index;
						scan_q <= '0;
						state_q <= (request.command == CMD_INTERN) ? S_HASH : S_RRD;
					end
				end
				S_HASH: begin
					if (hash_done) begin
						hash_q  <= hash_val;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					// wait state for the registered read of the scanned slot
					state_q <= (scan_q >= used_q) ? S_POP : S_CMP;
				end
				S_CMP: begin
					if (occ_q[scan_q[7:0]] && key_rd_q == key_q) begin
						result <= '{scan_q[7:0], ST_REUSED, hash_q, ref_wd};
						state_q <= S_OUT;
					end else begin
						scan_q  <= scan_q + 9'd1;
						state_q <= S_RD;
					end
				end
				S_POP: begin
					if (free_depth_q != 9'd0) begin
						slot_q       <= stack_rd_q;
						free_depth_q <= free_depth_q - 9'd1;
						state_q      <= S_STORE;
					end else if (used_q < 9'(ENTRIES)) begin
						slot_q  <= used_q[7:0];
						used_q  <= used_q + 9'd1;
						state_q <= S_STORE;
					end else begin
						result  <= '{8'd0, ST_FULL, hash_q, 16'd0};
						state_q <= S_OUT;
					end
				end
				S_STORE: begin
					occ_q[slot_q] <= 1'b1;
					result  <= '{slot_q, ST_ALLOC, hash_q, 16'd1};
					state_q <= S_OUT;
				end
				S_RRD: begin
					slot_q <= ridx_q;
					if (!occ_q[ridx_q]) begin
						result  <= '{8'd0, ST_IGNORED, 64'd0, 16'd0};
						state_q <= S_OUT;
					end else begin
						state_q <= S_RUPD;
					end
				end
				S_RUPD: begin
					if (refs_rd_q == 16'd1) begin
						occ_q[ridx_q] <= 1'b0;
						free_depth_q  <= free_depth_q + 9'd1;
						result <= '{ridx_q, ST_FREED, 64'd0, 16'd0};
					end else begin
						result <= '{ridx_q, ST_DROPPED, 64'd0, refs_rd_q - 16'd1};
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: design/rcdt_checker.sv
// Port checker for the refcounted dedup table, bound to the top level
`include "assert_macros.svh"
module rcdt_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input rcdt_pkg::result_t  result
);
	import rcdt_pkg::*;

	`CHK_NEXT(a_busy_after_start, clk, arst_n, start && !busy, busy)
	`CHK_IMPLY(a_done_ends_busy, clk, arst_n, done, !busy)
	`CHK_IMPLY(a_status_legal, clk, arst_n, done, result.status <= ST_IGNORED)
	`CHK_IMPLY(a_full_zero, clk, arst_n, done && result.status == ST_FULL,
		result.slot_index == 8'd0 && result.ref_count == 16'd0)
	`CHK_IMPLY(a_alloc_one, clk, arst_n, done && result.status == ST_ALLOC,
		result.ref_count == 16'd1)
endmodule

bind refcounted_dedup_table rcdt_checker u_rcdt_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done), .result(result)
);

FILE: tb/refcounted_dedup_table_tb.sv
// Testbench: random and directed requests to the refcounted dedup table, checked by a predictor
module refcounted_dedup_table_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rcdt_pkg::*;

	typedef struct {
		request_t    req;
		int unsigned gap;
	} pending_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	logic     busy;
	request_t request = '0;
	logic     done;
	result_t  result;

	pending_t    pending[$];
	result_t     expected_results[$];
	int unsigned errors = 0;
	int unsigned status_seen[8];
	int unsigned accepted = 0;

	// predictor state
	logic [63:0]         tbl_key[ENTRIES];
	logic [CNT_BITS-1:0] tbl_refs[ENTRIES];
	bit                  tbl_live[ENTRIES];
	logic [IDX_BITS-1:0] free_lifo[ENTRIES];
	int unsigned         free_cnt = 0;
	int unsigned         used_cnt = 0;

	logic [63:0] key_pool[32];

	refcounted_dedup_table u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result)
	);

	always #5 clk = ~clk;

	function automatic logic [63:0] fnv_hash(input logic [63:0] key);
		logic [63:0] h;
		h = FNV_OFFSET;
		for (int i = 0; i < 8; i++) begin
			h = h ^ {56'd0, key[8*i +: 8]};
			h = h * FNV_PRIME;
		end
		return h;
	endfunction

	function automatic result_t predict_table(input request_t req);
		result_t r;
		int      slot;
		r = '0;
		if (req.command == CMD_INTERN) begin
			r.key_hash = fnv_hash(req.key_value);
			for (int i = 0; i < ENTRIES; i++) begin
				if (tbl_live[i] && tbl_key[i] == req.key_value) begin
					if (tbl_refs[i] != '1)
						tbl_refs[i] = tbl_refs[i] + 1'b1;
					r.slot_index = i[IDX_BITS-1:0];
					r.status = ST_REUSED;
					r.ref_count = tbl_refs[i];
					return r;
				end
			end
			if (free_cnt > 0) begin
				free_cnt--;
				slot = int'(free_lifo[free_cnt]);
			end else if (used_cnt < ENTRIES) begin
				slot = int'(used_cnt);
				used_cnt++;
			end else begin
				r.status = ST_FULL;
				return r;
			end
			tbl_key[slot] = req.key_value;
			tbl_refs[slot] = CNT_BITS'(1);
			tbl_live[slot] = 1'b1;
			r.slot_index = slot[IDX_BITS-1:0];
			r.status = ST_ALLOC;
			r.ref_count = 16'd1;
		end else begin
			slot = int'(req.release_index);
			if (!tbl_live[slot]) begin
				r.status = ST_IGNORED;
				return r;
			end
			if (tbl_refs[slot] != 0)
				tbl_refs[slot] = tbl_refs[slot] - 1'b1;
			r.slot_index = req.release_index;
			if (tbl_refs[slot] == 0) begin
				tbl_live[slot] = 1'b0;
				free_lifo[free_cnt] = req.release_index;
				free_cnt++;
				r.status = ST_FREED;
			end else begin
				r.status = ST_DROPPED;
				r.ref_count = tbl_refs[slot];
			end
		end
		return r;
	endfunction

	// driver: hold a request until accepted, then maybe idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			request <= '0;
		end else if (!start || !busy) begin
			if (pending.size() > 0 && $urandom_range(99) >= pending[0].gap) begin
				start <= 1'b1;
				request <= pending.pop_front().req;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: check results, predict accepted requests
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result %p", $realtime, result);
					errors++;
				end else begin
					result_t e;
					e = expected_results.pop_front();
					status_seen[result.status]++;
					if (result.slot_index !== e.slot_index) begin
						$display("%0t: slot_index exp %0d got %0d", $realtime,
							e.slot_index, result.slot_index);
						errors++;
					end
					if (result.status !== e.status) begin
						$display("%0t: status exp %0d got %0d", $realtime, e.status,
							result.status);
						errors++;
					end
					if (result.key_hash !== e.key_hash) begin
						$display("%0t: key_hash exp %h got %h", $realtime, e.key_hash,
							result.key_hash);
						errors++;
					end
					if (result.ref_count !== e.ref_count) begin
						$display("%0t: ref_count exp %0d got %0d", $realtime,
							e.ref_count, result.ref_count);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				expected_results.insert(expected_results.size(), predict_table(request));
				accepted++;
			end
		end
	end

	task automatic add_req(input logic cmd, input logic [63:0] key, input logic [7:0] idx,
			input int unsigned gap);
		pending_t p;
		p.req.command = cmd;
		p.req.key_value = key;
		p.req.release_index = idx;
		p.gap = gap;
		pending.insert(pending.size(), p);
	endtask

	initial begin
		int unsigned gap;
		logic [63:0] k;
		for (int i = 0; i < ENTRIES; i++) begin
			tbl_key[i] = '0;
			tbl_refs[i] = '0;
			tbl_live[i] = 1'b0;
			free_lifo[i] = '0;
		end
		for (int i = 0; i < 32; i++)
			key_pool[i] = {$urandom, $urandom};

		// directed: extremes, reuse, drop, free, ignore, LIFO reuse of freed slots
		add_req(CMD_INTERN, 64'd0, 8'd0, 0);
		add_req(CMD_INTERN, '1, 8'hff, 0);
		add_req(CMD_INTERN, 64'd0, 8'd0, 0);
		add_req(CMD_RELEASE, '1, 8'd0, 0);
		add_req(CMD_RELEASE, 64'd0, 8'd0, 0);
		add_req(CMD_RELEASE, 64'd0, 8'd0, 0);
		add_req(CMD_RELEASE, 64'd0, 8'hff, 0);
		add_req(CMD_INTERN, 64'h0123456789abcdef, 8'd0, 0);
		add_req(CMD_INTERN, 64'h8000000000000001, 8'd0, 0);
		add_req(CMD_RELEASE, 64'd0, 8'd1, 0);
		add_req(CMD_RELEASE, 64'd0, 8'd2, 0);
		add_req(CMD_INTERN, 64'd5, 8'd0, 0);
		add_req(CMD_INTERN, 64'd6, 8'd0, 0);
		// stack a few references on one key, then release slot 0 (a single reference, so freed)
		for (int i = 0; i < 3; i++)
			add_req(CMD_INTERN, 64'ha5a5a5a5a5a5a5a5, 8'd0, 0);
		add_req(CMD_RELEASE, 64'd0, 8'd0, 0);

		// random: fill toward full, then drain
		for (int i = 0; i < 1050; i++) begin
			case ((i / 100) % 3)
				0: gap = 0;
				1: gap = 51;
				default: gap = 15;
			endcase
			k = ($urandom_range(1)) ? {$urandom, $urandom} : key_pool[$urandom_range(31)];
			if ($urandom_range(99) < ((i < 600) ? 70 : 40))
				add_req(CMD_INTERN, k, 8'($urandom_range(255)), gap);
			else
				add_req(CMD_RELEASE, k, 8'($urandom_range(255)), gap);
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending.size() == 0);
		@(posedge clk);
		while (start || expected_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("accepted %0d requests: reused %0d allocated %0d full %0d", accepted,
			status_seen[ST_REUSED], status_seen[ST_ALLOC], status_seen[ST_FULL]);
		$display("dropped %0d freed %0d ignored %0d", status_seen[ST_DROPPED],
			status_seen[ST_FREED], status_seen[ST_IGNORED]);
		if (errors == 0)
			$display("refcounted_dedup_table_tb OK");
		else
			$display("refcounted_dedup_table_tb NOT OK");
		$finish;
	end

	initial begin
		#40ms;
		$display("timeout");
		$display("refcounted_dedup_table_tb NOT OK");
		$finish;
	end
endmodule
